FILE: rtl/core/binary_image_unpack_crop_core_macros.svh
// Assertion macros shared by the unpack/crop core RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BINARY_IMAGE_UNPACK_CROP_CORE_MACROS_SVH
`define BINARY_IMAGE_UNPACK_CROP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define BIUC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("biuc: concurrent check failed");
`define BIUC_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("biuc: forbidden condition seen");
`else
`define BIUC_ASSERT(label, clk, rst_n, prop)
`define BIUC_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/biuc_pkg.sv
// Package for the binary image unpack/crop core: sizes, register codes,
// reset values and the structs passed between front, queue and back.
`default_nettype none

package biuc_pkg;

    // default geometry
    localparam int ROW_BYTES_DEF  = 20;
    localparam int FRAME_ROWS_DEF = 120;
    localparam int OUT_WIDTH_DEF  = 128;

    // pixels per output group
    localparam int GROUP_PIX = 8;

    // signed window offset; covers -512..512 for the largest geometry
    localparam int OFFS_W = 11;
    // running column inside the back end (offset plus window width)
    localparam int COL_W  = OFFS_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ROW_IDX_W  = 7;
    localparam int GRP_IDX_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_OFFSET     = 3'd0,
        CFG_LEFT_FILL_ZERO  = 3'd1,
        CFG_STEER_ENABLE    = 3'd2,
        CFG_STEER_ANGLE     = 3'd3,
        CFG_STEER_THRESHOLD = 3'd4,
        CFG_STEER_SHIFT     = 3'd5,
        CFG_ROWS_KEPT       = 3'd6
    } cfg_reg_t;

    localparam logic [7:0] RST_BASE_OFFSET     = 8'd26;
    localparam logic       RST_LEFT_FILL_ZERO  = 1'b0;
    localparam logic       RST_STEER_ENABLE    = 1'b0;
    localparam logic [7:0] RST_STEER_ANGLE     = 8'd0;
    localparam logic [6:0] RST_STEER_THRESHOLD = 7'd30;
    localparam logic [5:0] RST_STEER_SHIFT     = 6'd15;
    localparam logic [6:0] RST_ROWS_KEPT       = 7'd70;

    localparam logic [7:0] PIX_WHITE = 8'hFF;
    localparam logic [7:0] PIX_BLACK = 8'h00;

    // one kept row waiting to be cropped
    typedef struct packed {
        logic                     bank;
        logic [ROW_IDX_W-1:0]     row_index;
        logic signed [OFFS_W-1:0] offset;
        logic                     left_fill_zero;
    } job_t;

    // back end hands a line bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/biuc_line_store.sv
// Two-bank line store: one bank fills from the byte stream while the other
// is read out as a flat pixel-bit vector. Uses biuc_pkg.
`default_nettype none

module biuc_line_store #(
    parameter int ROW_BYTES = biuc_pkg::ROW_BYTES_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic                                        wr_bank,
    input  wire logic [((ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1)-1:0] wr_byte,
    input  wire logic [7:0]                                  wr_data,
    input  wire logic                                        rd_bank,
    output logic      [ROW_BYTES*8-1:0]                      rd_line
);

    localparam int ROW_PIX    = ROW_BYTES * 8;
    localparam int BYTE_IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    // bit c holds pixel column c; 1 = black
    logic [ROW_PIX-1:0] line_reg [2];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int j = 0; j < ROW_BYTES; j++)
            begin
                if (wr_byte == BYTE_IDX_W'(j))
                begin
                    // MSB of the byte is the leftmost column
                    for (int i = 0; i < 8; i++)
                    begin
                        line_reg[wr_bank][j*8 + i] <= wr_data[7-i];
                    end
                end
            end
        end
    end

    assign rd_line = line_reg[rd_bank];

endmodule

`default_nettype wire

FILE: rtl/core/biuc_job_queue.sv
// Two-entry job queue between the front end and the back end.
// Uses biuc_pkg::job_t.
`default_nettype none

module biuc_job_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire biuc_pkg::job_t push_job,
    input  wire logic           pop,
    output biuc_pkg::job_t      head_job,
    output logic                empty,
    output logic                full
);

    biuc_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: rtl/core/biuc_front.sv
// Front end: config registers, byte intake, row/frame counting, window
// offset and job issue. Uses biuc_pkg and the assertion macro header.
`default_nettype none
`include "binary_image_unpack_crop_core_macros.svh"

module biuc_front #(
    parameter int ROW_BYTES  = biuc_pkg::ROW_BYTES_DEF,
    parameter int FRAME_ROWS = biuc_pkg::FRAME_ROWS_DEF,
    parameter int OUT_WIDTH  = biuc_pkg::OUT_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // config
    input  wire logic                                  cfg_wr_en,
    input  wire logic [biuc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [biuc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // byte stream
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    // line store write side
    output logic                                       ls_wr_en,
    output logic                                       ls_wr_bank,
    output logic [((ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1)-1:0] ls_wr_byte,
    // job queue
    output logic                                       q_push,
    output biuc_pkg::job_t                             q_job,
    input  wire logic                                  q_full,
    // bank handback from the back end
    input  wire biuc_pkg::release_t                    rel
);

    localparam int ROW_PIX    = ROW_BYTES * 8;
    localparam int BYTE_IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_CNT_W  = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
    localparam int KEEP_W     = (ROW_CNT_W > 7) ? ROW_CNT_W : 7;
    localparam int OW         = biuc_pkg::OFFS_W;
    localparam logic signed [OW-1:0] OFFS_MIN = OW'(-OUT_WIDTH);
    localparam logic signed [OW-1:0] OFFS_MAX = OW'(ROW_PIX);

    // config registers
    logic [7:0] base_offset_reg;
    logic       left_fill_zero_reg;
    logic       steer_enable_reg;
    logic [7:0] steer_angle_reg;
    logic [6:0] steer_threshold_reg;
    logic [5:0] steer_shift_reg;
    logic [6:0] rows_kept_reg;

    logic [BYTE_IDX_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [ROW_CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic                  wr_bank_reg, wr_bank_next;
    logic [1:0]            busy_reg, busy_next;

    logic                  accept, last_byte, row_kept;
    logic [KEEP_W-1:0]     row_ext, keep_ext;
    logic signed [8:0]     angle9, thr9, neg_thr9;
    logic signed [OW-1:0]  adj, offs_sum, offs_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg     <= biuc_pkg::RST_BASE_OFFSET;
            left_fill_zero_reg  <= biuc_pkg::RST_LEFT_FILL_ZERO;
            steer_enable_reg    <= biuc_pkg::RST_STEER_ENABLE;
            steer_angle_reg     <= biuc_pkg::RST_STEER_ANGLE;
            steer_threshold_reg <= biuc_pkg::RST_STEER_THRESHOLD;
            steer_shift_reg     <= biuc_pkg::RST_STEER_SHIFT;
            rows_kept_reg       <= biuc_pkg::RST_ROWS_KEPT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                biuc_pkg::CFG_BASE_OFFSET:     base_offset_reg     <= cfg_data;
                biuc_pkg::CFG_LEFT_FILL_ZERO:  left_fill_zero_reg  <= cfg_data[0];
                biuc_pkg::CFG_STEER_ENABLE:    steer_enable_reg    <= cfg_data[0];
                biuc_pkg::CFG_STEER_ANGLE:     steer_angle_reg     <= cfg_data;
                biuc_pkg::CFG_STEER_THRESHOLD: steer_threshold_reg <= cfg_data[6:0];
                biuc_pkg::CFG_STEER_SHIFT:     steer_shift_reg     <= cfg_data[5:0];
                biuc_pkg::CFG_ROWS_KEPT:       rows_kept_reg       <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // a bank still waiting on the back end cannot be refilled
    assign in_ready  = !busy_reg[wr_bank_reg];
    assign accept    = in_valid && in_ready;
    assign last_byte = (byte_cnt_reg == BYTE_IDX_W'(ROW_BYTES - 1));

    assign row_ext  = KEEP_W'(row_cnt_reg);
    assign keep_ext = KEEP_W'(rows_kept_reg);
    assign row_kept = (row_ext < keep_ext);

    // steering shift and saturated window offset
    always_comb
    begin
        angle9   = $signed({steer_angle_reg[7], steer_angle_reg});
        thr9     = $signed({2'b00, steer_threshold_reg});
        neg_thr9 = -thr9;
        adj      = '0;
        if (steer_enable_reg)
        begin
            if (angle9 > thr9)
            begin
                adj = -$signed(OW'(steer_shift_reg));
            end
            else if (angle9 < neg_thr9)
            begin
                adj = $signed(OW'(steer_shift_reg));
            end
        end
        offs_sum = $signed({{(OW-8){base_offset_reg[7]}}, base_offset_reg}) + adj;
        if (offs_sum < OFFS_MIN)
        begin
            offs_sat = OFFS_MIN;
        end
        else if (offs_sum > OFFS_MAX)
        begin
            offs_sat = OFFS_MAX;
        end
        else
        begin
            offs_sat = offs_sum;
        end
    end

    assign ls_wr_en   = accept;
    assign ls_wr_bank = wr_bank_reg;
    assign ls_wr_byte = byte_cnt_reg;

    assign q_push               = accept && last_byte && row_kept;
    assign q_job.bank           = wr_bank_reg;
    assign q_job.row_index      = biuc_pkg::ROW_IDX_W'(row_cnt_reg);
    assign q_job.offset         = offs_sat;
    assign q_job.left_fill_zero = left_fill_zero_reg;

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        wr_bank_next  = wr_bank_reg;
        busy_next     = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (last_byte)
            begin
                byte_cnt_next = '0;
                if (row_cnt_reg == ROW_CNT_W'(FRAME_ROWS - 1))
                begin
                    row_cnt_next = '0;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
                // dropped rows reuse the same bank
                if (row_kept)
                begin
                    busy_next[wr_bank_reg] = 1'b1;
                    wr_bank_next           = !wr_bank_reg;
                end
            end
            else
            begin
                byte_cnt_next = byte_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            row_cnt_reg  <= '0;
            wr_bank_reg  <= 1'b0;
            busy_reg     <= 2'b00;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            wr_bank_reg  <= wr_bank_next;
            busy_reg     <= busy_next;
        end
    end

    `BIUC_ASSERT(a_rel_busy_bank, clk, rst_n, rel.valid |-> busy_reg[rel.bank])
    `BIUC_NEVER(a_push_full, clk, rst_n, q_push && q_full)
    `BIUC_ASSERT(a_push_flips_bank, clk, rst_n, q_push |=> wr_bank_reg != $past(wr_bank_reg))

endmodule

`default_nettype wire

FILE: rtl/core/biuc_back.sv
// Back end: pops a row job, walks the window one group of eight pixels per
// cycle into an output register, holding while out_ready stalls it. Uses biuc_pkg.
`default_nettype none

module biuc_back #(
    parameter int ROW_BYTES = biuc_pkg::ROW_BYTES_DEF,
    parameter int OUT_WIDTH = biuc_pkg::OUT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // job queue
    input  wire logic                               q_empty,
    input  wire biuc_pkg::job_t                     q_job,
    output logic                                    q_pop,
    // line store read side
    output logic                                    rd_bank,
    input  wire logic [ROW_BYTES*8-1:0]             rd_line,
    // bank handback
    output biuc_pkg::release_t                      rel,
    // result stream
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [63:0]                             pixel_group,
    output logic [biuc_pkg::ROW_IDX_W-1:0]          row_index,
    output logic [biuc_pkg::GRP_IDX_W-1:0]          group_index,
    output logic                                    last_of_row
);

    localparam int ROW_PIX  = ROW_BYTES * 8;
    localparam int IDX_W    = $clog2(ROW_PIX);
    localparam int GROUPS   = OUT_WIDTH / biuc_pkg::GROUP_PIX;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW       = biuc_pkg::COL_W;
    // right fill source column
    localparam int RFILL    = (OUT_WIDTH - 1 < ROW_PIX - 1) ? OUT_WIDTH - 1 : ROW_PIX - 1;

    biuc_pkg::back_state_t state_reg, state_next;

    logic                          bank_reg;
    logic [biuc_pkg::ROW_IDX_W-1:0] row_reg;
    logic signed [CW-1:0]          col_reg;
    logic                          lfz_reg;
    logic [GRP_W-1:0]              grp_reg;

    logic                          out_valid_reg;
    logic [63:0]                   pixel_group_reg;
    logic [biuc_pkg::ROW_IDX_W-1:0] row_index_reg;
    logic [biuc_pkg::GRP_IDX_W-1:0] group_index_reg;
    logic                          last_reg;

    logic                          load, last_grp;
    logic [63:0]                   group_pix;
    logic signed [CW-1:0]          src_col;
    logic                          black;

    assign last_grp = (grp_reg == GRP_W'(GROUPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            biuc_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = biuc_pkg::BK_RUN;
                end
            end
            biuc_pkg::BK_RUN:
            begin
                if (load && last_grp)
                begin
                    state_next = biuc_pkg::BK_IDLE;
                end
            end
            default: state_next = biuc_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop = 1'b0;
        load  = 1'b0;
        case (state_reg)
            biuc_pkg::BK_IDLE: q_pop = !q_empty;
            biuc_pkg::BK_RUN:  load  = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign rel.valid = load && last_grp;
    assign rel.bank  = bank_reg;
    assign rd_bank   = bank_reg;

    // eight source columns, leftmost into the high byte
    always_comb
    begin
        group_pix = '0;
        src_col   = '0;
        black     = 1'b0;
        for (int p = 0; p < biuc_pkg::GROUP_PIX; p++)
        begin
            src_col = col_reg + CW'(p);
            if (src_col[CW-1])
            begin
                black = lfz_reg ? 1'b1 : rd_line[0];
            end
            else if (src_col >= $signed(CW'(ROW_PIX)))
            begin
                black = rd_line[RFILL];
            end
            else
            begin
                black = rd_line[src_col[IDX_W-1:0]];
            end
            group_pix[63 - 8*p -: 8] = black ? biuc_pkg::PIX_BLACK : biuc_pkg::PIX_WHITE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= biuc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bank_reg <= q_job.bank;
            row_reg  <= q_job.row_index;
            col_reg  <= {q_job.offset[biuc_pkg::OFFS_W-1], q_job.offset};
            lfz_reg  <= q_job.left_fill_zero;
            grp_reg  <= '0;
        end
        else if (load)
        begin
            grp_reg <= grp_reg + 1'b1;
            col_reg <= col_reg + CW'(biuc_pkg::GROUP_PIX);
        end
        if (load)
        begin
            pixel_group_reg <= group_pix;
            row_index_reg   <= row_reg;
            group_index_reg <= biuc_pkg::GRP_IDX_W'(grp_reg);
            last_reg        <= last_grp;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_group = pixel_group_reg;
    assign row_index   = row_index_reg;
    assign group_index = group_index_reg;
    assign last_of_row = last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/binary_image_unpack_crop_core.sv
// Top level of the binary image unpack/crop core: front end, two-bank line
// store, job queue and back end. Uses biuc_pkg.
//
//   channel   signals                                   handshake
//   --------  ----------------------------------------  ------------------
//   in        packed_byte                               in_valid/in_ready
//   out       pixel_group, row_index, group_index,      out_valid/out_ready
//             last_of_row
//   cfg       cfg_index, cfg_data                       cfg_wr_en (no wait)
//
// One byte is taken per cycle while in_ready is high. The last byte of a kept
// row queues a job; its OUT_WIDTH/8 groups leave one per cycle unless out_ready
// stalls them. The two line banks let the next row load while the previous one
// drains, so input stalls only when both banks hold rows not yet fully emitted.
// Reset clears counters, bank flags, queue, presets config; no clearing pass.
`default_nettype none

module binary_image_unpack_crop_core #(
    parameter int ROW_BYTES  = biuc_pkg::ROW_BYTES_DEF,
    parameter int FRAME_ROWS = biuc_pkg::FRAME_ROWS_DEF,
    parameter int OUT_WIDTH  = biuc_pkg::OUT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [biuc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [biuc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         packed_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [63:0]                             pixel_group,
    output logic [biuc_pkg::ROW_IDX_W-1:0]          row_index,
    output logic [biuc_pkg::GRP_IDX_W-1:0]          group_index,
    output logic                                    last_of_row
);

    localparam int BYTE_IDX_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    logic                   ls_wr_en, ls_wr_bank, rd_bank;
    logic [BYTE_IDX_W-1:0]  ls_wr_byte;
    logic [ROW_BYTES*8-1:0] rd_line;
    logic                   q_push, q_pop, q_empty, q_full;
    biuc_pkg::job_t         push_job, head_job;
    biuc_pkg::release_t     rel;

    biuc_front #(
        .ROW_BYTES  (ROW_BYTES),
        .FRAME_ROWS (FRAME_ROWS),
        .OUT_WIDTH  (OUT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ls_wr_en    (ls_wr_en),
        .ls_wr_bank  (ls_wr_bank),
        .ls_wr_byte  (ls_wr_byte),
        .q_push      (q_push),
        .q_job       (push_job),
        .q_full      (q_full),
        .rel         (rel)
    );

    biuc_line_store #(
        .ROW_BYTES (ROW_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_bank (ls_wr_bank),
        .wr_byte (ls_wr_byte),
        .wr_data (packed_byte),
        .rd_bank (rd_bank),
        .rd_line (rd_line)
    );

    biuc_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    biuc_back #(
        .ROW_BYTES (ROW_BYTES),
        .OUT_WIDTH (OUT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .rd_bank     (rd_bank),
        .rd_line     (rd_line),
        .rel         (rel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_group (pixel_group),
        .row_index   (row_index),
        .group_index (group_index),
        .last_of_row (last_of_row)
    );

endmodule

`default_nettype wire
